// ===== rtl/cmcg_pkg.sv =====
// ----------------------------------------------------------------------------
// cmcg_pkg
// Shared types, sizes and arithmetic helpers of the max-channel gradient block.
// ----------------------------------------------------------------------------
package cmcg_pkg;

	localparam int MAX_WIDTH          = 2048;
	localparam int HEIGHT_LIMIT       = 4096;
	localparam int COL_W              = $clog2(MAX_WIDTH);
	localparam int ROW_W              = $clog2(HEIGHT_LIMIT);
	localparam int FRAME_WIDTH_W      = 12;
	localparam int FRAME_HEIGHT_W     = 13;
	localparam int CFG_DATA_W         = 13;
	localparam int FRAME_WIDTH_RESET  = 640;
	localparam int FRAME_HEIGHT_RESET = 480;
	localparam int QUEUE_DEPTH        = 4;
	localparam int QPTR_W             = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W             = $clog2(QUEUE_DEPTH + 1);
	localparam int MAG_MAX            = 255;

	// configuration register indexes
	localparam logic REG_FRAME_WIDTH  = 1'b0;
	localparam logic REG_FRAME_HEIGHT = 1'b1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	// one line store entry: the pixel of the newest row and of the row before
	typedef struct packed {
		pix_t recent;
		pix_t older;
	} line_ent_t;

	localparam int ENT_W = $bits(line_ent_t);

	typedef struct packed {
		logic row_first;
		logic row_second;
		logic row_last;
		logic col_first;
		logic col_second;
		logic col_last;
	} pos_t;

	// column record handed from front to back
	typedef struct packed {
		pix_t cur;     // incoming pixel, row r
		pix_t above;   // row r-1, same column
		pix_t above2;  // row r-2, same column
		pix_t ahead;   // row r-1, next column
		pos_t pos;
	} rec_t;

	function automatic logic [7:0] abs_diff(input logic [7:0] a, input logic [7:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	function automatic logic [7:0] max_dist(input pix_t a, input pix_t b);
		logic [7:0] db;
		logic [7:0] dg;
		logic [7:0] dr;
		logic [7:0] m;
		db = abs_diff(a.blue, b.blue);
		dg = abs_diff(a.green, b.green);
		dr = abs_diff(a.red, b.red);
		m = db;
		if (dg > m) m = dg;
		if (dr > m) m = dr;
		return m;
	endfunction

	// one-sided differences at the frame border count twice
	function automatic logic [8:0] scale_dist(input logic [7:0] d, input logic twice);
		return twice ? {d, 1'b0} : {1'b0, d};
	endfunction

	function automatic logic [7:0] sat_sum(input logic [8:0] gx, input logic [8:0] gy);
		logic [9:0] s;
		s = {1'b0, gx} + {1'b0, gy};
		return (s > 10'(MAG_MAX)) ? 8'(MAG_MAX) : s[7:0];
	endfunction

	function automatic logic [COL_W-1:0] width_last(input logic [FRAME_WIDTH_W-1:0] w);
		if (w < FRAME_WIDTH_W'(2)) return COL_W'(1);
		else if (int'(w) > MAX_WIDTH) return COL_W'(MAX_WIDTH - 1);
		else return COL_W'(w - 1'b1);
	endfunction

	function automatic logic [ROW_W-1:0] height_last(input logic [FRAME_HEIGHT_W-1:0] h);
		if (h < FRAME_HEIGHT_W'(2)) return ROW_W'(1);
		else if (int'(h) > HEIGHT_LIMIT) return ROW_W'(HEIGHT_LIMIT - 1);
		else return ROW_W'(h - 1'b1);
	endfunction

endpackage

// ===== rtl/cmcg_ram.sv =====
// ----------------------------------------------------------------------------
// cmcg_ram
// Simple dual-port RAM, one write and one registered read per clock.
// ----------------------------------------------------------------------------
module cmcg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata <= mem[raddr];
	end

endmodule

// ===== rtl/cmcg_front.sv =====
// ----------------------------------------------------------------------------
// cmcg_front
// Accepts pixels, tracks raster position and maintains the line store.
// Each pixel leaves as a column record carrying its vertical and look-ahead
// neighbours.
// ----------------------------------------------------------------------------
module cmcg_front import cmcg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            blue,
	input  logic [7:0]            green,
	input  logic [7:0]            red,
	input  logic [QCNT_W-1:0]     q_count,
	output logic                  push,
	output rec_t                  push_rec
);

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_last_q;
	logic [ROW_W-1:0] row_last_q;
	logic             s1_valid_s1;
	pix_t             cur_s1;
	pix_t             above_s1;
	pix_t             above2_s1;
	pos_t             pos_s1;

	logic             acc;
	pos_t             pos;
	pix_t             cur_pix;
	line_ent_t        rd_ent;
	logic [ENT_W-1:0] ram_rdata;
	logic [COL_W-1:0] ram_raddr;
	line_ent_t        wr_ent;

	// the record in s1 always lands in the queue next cycle, so count it too
	assign in_stall = ({1'b0, q_count} + (QCNT_W + 1)'(s1_valid_s1))
		>= (QCNT_W + 1)'(QUEUE_DEPTH);
	assign acc = in_valid & ~in_stall;

	assign cur_pix = '{red: red, green: green, blue: blue};

	always_comb begin
		pos.row_first  = (row_q == '0);
		pos.row_second = (row_q == ROW_W'(1));
		pos.row_last   = (row_q == row_last_q);
		pos.col_first  = (col_q == '0);
		pos.col_second = (col_q == COL_W'(1));
		pos.col_last   = (col_q == col_last_q);
	end

	// read data holds the entry of the current column, fetched one pixel earlier
	assign rd_ent = line_ent_t'(ram_rdata);
	assign wr_ent = '{recent: cur_pix, older: rd_ent.recent};
	assign ram_raddr = pos.col_last ? '0 : (col_q + COL_W'(1));

	cmcg_ram #(
		.WIDTH (ENT_W),
		.DEPTH (MAX_WIDTH)
	) u_line_ram (
		.clk   (clk),
		.we    (acc),
		.waddr (col_q),
		.wdata (wr_ent),
		.re    (acc),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			col_last_q  <= COL_W'(FRAME_WIDTH_RESET - 1);
			row_last_q  <= ROW_W'(FRAME_HEIGHT_RESET - 1);
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= acc;
			if (cfg_write) begin
				unique case (cfg_index)
					REG_FRAME_WIDTH:  col_last_q <= width_last(cfg_data[FRAME_WIDTH_W-1:0]);
					REG_FRAME_HEIGHT: row_last_q <= height_last(cfg_data[FRAME_HEIGHT_W-1:0]);
				endcase
				col_q <= '0;
				row_q <= '0;
			end else if (acc) begin
				if (pos.col_last) begin
					col_q <= '0;
					row_q <= pos.row_last ? '0 : (row_q + ROW_W'(1));
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cur_s1    <= cur_pix;
			above_s1  <= rd_ent.recent;
			above2_s1 <= rd_ent.older;
			pos_s1    <= pos;
		end
	end

	// look-ahead read issued at acceptance is on rdata now
	assign push = s1_valid_s1;
	assign push_rec = '{
		cur:    cur_s1,
		above:  above_s1,
		above2: above2_s1,
		ahead:  rd_ent.recent,
		pos:    pos_s1
	};

endmodule

// ===== rtl/cmcg_queue.sv =====
// ----------------------------------------------------------------------------
// cmcg_queue
// Short FIFO of column records between front and back.
// ----------------------------------------------------------------------------
module cmcg_queue import cmcg_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  rec_t              push_rec,
	input  logic              pop,
	output rec_t              head_rec,
	output logic              filled,
	output logic [QCNT_W-1:0] count
);

	rec_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : (p + QPTR_W'(1));
	endfunction

	assign head_rec = slot_q[rd_ptr_q];
	assign filled   = (count_q != '0);
	assign count    = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop)  rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_rec;
	end

endmodule

// ===== rtl/cmcg_back.sv =====
// ----------------------------------------------------------------------------
// cmcg_back
// Turns column records into gradient magnitudes (up to three per record) and
// hands them out one per transfer from a result register.
// ----------------------------------------------------------------------------
module cmcg_back import cmcg_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  rec_t       head_rec,
	input  logic       q_filled,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] magnitude,
	output logic       frame_end
);

	// result slots, emitted lowest first
	localparam int RES_UPPER = 0;  // row r-1, column c
	localparam int RES_LEFT  = 1;  // last row, column c-1
	localparam int RES_FINAL = 2;  // last row, last column

	logic [2:0] mask_q;
	logic [7:0] mag_q [3];
	pix_t       above_prev_q;  // row r-1, column c-1
	pix_t       cur_prev_q;    // row r, column c-1
	pix_t       cur_prev2_q;   // row r, column c-2

	logic [2:0] sel;
	logic       xfer;
	logic [2:0] new_mask;
	logic [7:0] new_mag [3];
	logic [7:0] dh_up;
	logic [7:0] dv_up;
	logic [7:0] dh_left;
	logic       edge_col;
	rec_t       r;

	assign r = head_rec;

	always_comb begin
		edge_col = r.pos.col_first | r.pos.col_last;
		if (r.pos.col_first)     dh_up = max_dist(r.ahead, r.above);
		else if (r.pos.col_last) dh_up = max_dist(r.above, above_prev_q);
		else                     dh_up = max_dist(above_prev_q, r.ahead);
		dv_up = r.pos.row_second ? max_dist(r.cur, r.above) : max_dist(r.above2, r.cur);
		new_mag[RES_UPPER] = sat_sum(scale_dist(dh_up, edge_col),
			scale_dist(dv_up, r.pos.row_second));

		dh_left = r.pos.col_second ? max_dist(r.cur, cur_prev_q)
			: max_dist(cur_prev2_q, r.cur);
		new_mag[RES_LEFT] = sat_sum(scale_dist(dh_left, r.pos.col_second),
			scale_dist(max_dist(cur_prev_q, above_prev_q), 1'b1));

		new_mag[RES_FINAL] = sat_sum(scale_dist(max_dist(r.cur, cur_prev_q), 1'b1),
			scale_dist(max_dist(r.cur, r.above), 1'b1));

		new_mask[RES_UPPER] = ~r.pos.row_first;
		new_mask[RES_LEFT]  = r.pos.row_last & ~r.pos.col_first;
		new_mask[RES_FINAL] = r.pos.row_last & r.pos.col_last;
	end

	assign sel       = mask_q & (~mask_q + 3'b001);
	assign out_valid = (mask_q != '0);
	assign xfer      = out_valid & ~out_stall;
	// next record comes in once the current set is drained or on its last transfer
	assign pop       = q_filled & ((mask_q == '0) | (xfer & (mask_q == sel)));

	always_comb begin
		if (sel[RES_UPPER])     magnitude = mag_q[RES_UPPER];
		else if (sel[RES_LEFT]) magnitude = mag_q[RES_LEFT];
		else                    magnitude = mag_q[RES_FINAL];
	end
	assign frame_end = sel[RES_FINAL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (pop) begin
			mask_q <= new_mask;
		end else if (xfer) begin
			mask_q <= mask_q & ~sel;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mag_q[RES_UPPER] <= new_mag[RES_UPPER];
			mag_q[RES_LEFT]  <= new_mag[RES_LEFT];
			mag_q[RES_FINAL] <= new_mag[RES_FINAL];
			above_prev_q     <= r.above;
			cur_prev_q       <= r.cur;
			cur_prev2_q      <= cur_prev_q;
		end
	end

endmodule

// ===== rtl/color_max_channel_gradient.sv =====
// ----------------------------------------------------------------------------
// color_max_channel_gradient
// Max-channel central-difference gradient magnitude on a BGR pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter in raster order at up to one per clock; the line store is a
// single 2048 x 48 RAM (one read and one write per pixel) holding the last two
// rows per column, so no clearing pass follows reset. Results lag by one row:
// each pixel of row r gives the magnitude of the pixel above it, and during
// the last row each pixel also gives the one to its left, the final pixel a
// third result flagged with frame_end. Results leave at one per clock while
// out_stall is low, so the last row, where most pixels give two results, runs
// slower; elsewhere one pixel per clock is sustained with out_stall low. Any
// configuration write restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module color_max_channel_gradient import cmcg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            blue,
	input  logic [7:0]            green,
	input  logic [7:0]            red,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [7:0]            magnitude,
	output logic                  frame_end
);

	logic              push;
	rec_t              push_rec;
	logic              pop;
	rec_t              head_rec;
	logic              q_filled;
	logic [QCNT_W-1:0] q_count;

	cmcg_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.blue      (blue),
		.green     (green),
		.red       (red),
		.q_count   (q_count),
		.push      (push),
		.push_rec  (push_rec)
	);

	cmcg_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_rec (push_rec),
		.pop      (pop),
		.head_rec (head_rec),
		.filled   (q_filled),
		.count    (q_count)
	);

	cmcg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_rec  (head_rec),
		.q_filled  (q_filled),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.magnitude (magnitude),
		.frame_end (frame_end)
	);

endmodule
